// ===== hdl/dlte_pkg.sv =====
// shared types, codes and fixed-point helpers of the dense layer training engine
package dlte_pkg;

    localparam int DATA_W    = 16;
    localparam int ACC_W     = 32;
    localparam int FRAC      = 12;
    localparam int WIDE_W    = 36;
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 7;
    localparam int LR_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef enum logic [FUNC_W-1:0] {
        FN_FWD, FN_BWD, FN_UPD, FN_LDW, FN_LDB
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KD_FWD, KD_GRAD, KD_DONE
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_COUNT, CFG_OUT_COUNT, CFG_LRATE
    } t_cfg_idx;

    // saturating accumulate
    function automatic t_acc sat_add(t_acc a, t_acc b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // q4.12 into the q8.24 accumulator format
    function automatic t_acc to_acc(t_data d);
        return t_acc'(d) <<< FRAC;
    endfunction

    function automatic t_data sat_data(t_wide x);
        if (&x[WIDE_W-1:DATA_W-1] || ~|x[WIDE_W-1:DATA_W-1]) begin
            return x[DATA_W-1:0];
        end
        return x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // q8.24 to q4.12, round half up
    function automatic t_data round_q(t_acc a);
        t_wide r;
        r = t_wide'(a >>> FRAC) + t_wide'({1'b0, a[FRAC-1]});
        return sat_data(r);
    endfunction

    // old - round(lr * grad), grad split in two 16-bit halves
    function automatic t_data upd_val(t_data old, logic [31:0] pl, logic signed [32:0] ph);
        logic [32:0]        lowp;
        logic signed [33:0] sum;
        logic signed [21:0] step;
        t_wide              d;
        lowp = 33'(pl) + 33'(34'd1 << 27);
        sum  = 34'(ph) + 34'(lowp[32:16]);
        step = 22'(sum >>> FRAC);
        d    = t_wide'(old) - t_wide'(step);
        return sat_data(d);
    endfunction

endpackage

// ===== hdl/dlte_in_if.sv =====
// input channel of the dense layer training engine
interface dlte_in_if import dlte_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
    logic                    last;

    modport source (output valid, func, row, col, value, last, input ready);
    modport sink   (input valid, func, row, col, value, last, output ready);
endinterface

// ===== hdl/dlte_out_if.sv =====
// result channel of the dense layer training engine
interface dlte_out_if import dlte_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] result;
    logic                     final_res;

    modport source (output valid, kind, index, result, final_res, input ready);
    modport sink   (input valid, kind, index, result, final_res, output ready);
endinterface

// ===== hdl/dense_layer_train_engine.sv =====
// dense layer training engine: memories, sequencer and result register
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------
//  in_ch    | in  | valid / ready  | func, row, col, value, last
//  out_ch   | out | valid / ready  | kind, index, result, final_res
//  cfg      | in  | i_cfg_we       | i_cfg_idx, i_cfg_data
//
// after reset a clearing pass walks every entry and zeroes all stores; no
// transaction is taken during it (configuration writes are)
// the sequencer walks the memories with a read, a multiply and an accumulate
// (and write back) state per element; loads and plain forward items leave it
// idle, a backward item walks its row and bias plus, when last, the grad-input
// outputs, a final forward item walks every active output neuron, and an update
// walks every stored weight and then every stored bias
// a result waits in the output register; a stalled consumer holds the sequencer
module dense_layer_train_engine
    import dlte_pkg::*;
#(
    parameter int IN_MAX  = 64,
    parameter int OUT_MAX = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dlte_in_if.sink              in_ch,
    dlte_out_if.source           out_ch
);

    localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int K  = IN_MAX * OUT_MAX;
    localparam int KW = (K > 1) ? $clog2(K) : 1;
    localparam int LW = 12;   // wide enough for counts, fields and maxima

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        F_BRD, F_BINIT, F_RD, F_MUL, F_ACC, F_EMIT,
        B_RD, B_MUL, B_ACC, B_BRD, B_BACC,
        G_RD, G_EMIT,
        U_RD, U_MUL, U_ACC, U_BRD, U_BMUL, U_BACC, U_DONE
    } t_state;

    // configuration
    logic [CNT_W-1:0] r_in_count, r_out_count;
    logic [LR_W-1:0]  r_lrate;

    // sequencer
    t_state             r_state;
    logic [OW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic [KW-1:0]      r_k;
    t_data              r_v;
    logic               r_last;
    t_acc               r_acc;
    t_acc               r_p1, r_p2;
    logic [31:0]        r_pl;
    logic signed [32:0] r_ph;

    // result register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;
    t_data             r_res;
    logic              r_fin;

    // memories and their read data
    t_data mem_w  [K];
    t_acc  mem_wg [K];
    t_data mem_b  [OUT_MAX];
    t_acc  mem_bg [OUT_MAX];
    t_data mem_c  [IN_MAX];
    t_acc  mem_ga [IN_MAX];
    t_data r_w_q, r_b_q, r_c_q;
    t_acc  r_wg_q, r_bg_q, r_ga_q;

    logic          w_we, w_re, wg_we, wg_re, b_we, b_re, bg_we, bg_re;
    logic          c_we, c_re, ga_we, ga_re;
    logic [KW-1:0] w_a, wg_a, k_ij, k_ld;
    logic [OW-1:0] b_a, bg_a;
    logic [IW-1:0] c_a, ga_a;
    t_data         w_d, b_d, c_d;
    t_acc          wg_d, bg_d, ga_d;

    logic [LW-1:0] ni, no;
    logic          acc_in, slot_free, j_last, i_last, k_last, iu_last;
    logic          clr_out, clr_in, row_ok, ld_w_ok, ld_b_ok, col_ok, do_emit;
    t_func         fn;
    t_data         upd_w, upd_b;

    // effective counts: zero acts as one, beyond the maximum clamps
    always_comb begin
        ni = (r_in_count == '0) ? LW'(1) :
             (LW'(r_in_count) > LW'(IN_MAX)) ? LW'(IN_MAX) : LW'(r_in_count);
        no = (r_out_count == '0) ? LW'(1) :
             (LW'(r_out_count) > LW'(OUT_MAX)) ? LW'(OUT_MAX) : LW'(r_out_count);
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign acc_in      = in_ch.valid && in_ch.ready;
    assign fn          = t_func'(in_ch.func);
    assign slot_free   = !r_out_valid || out_ch.ready;
    // a result is loaded into the output register this cycle
    assign do_emit     = slot_free && (r_state == F_EMIT || r_state == G_EMIT ||
                                       r_state == U_DONE);

    assign j_last  = (LW'(r_j) + LW'(1)) == ni;
    assign i_last  = (LW'(r_i) + LW'(1)) == no;
    assign k_last  = (r_k == KW'(K - 1));
    assign iu_last = (r_i == OW'(OUT_MAX - 1));
    assign clr_out = ({1'b0, r_k} < (KW+1)'(OUT_MAX));
    assign clr_in  = ({1'b0, r_k} < (KW+1)'(IN_MAX));
    assign row_ok  = LW'(in_ch.row) < no;
    assign col_ok  = LW'(in_ch.col) < ni;
    assign ld_b_ok = LW'(in_ch.row) < LW'(OUT_MAX);
    assign ld_w_ok = ld_b_ok && (LW'(in_ch.col) < LW'(IN_MAX));

    assign k_ij = KW'(r_i) * KW'(IN_MAX) + KW'(r_j);
    assign k_ld = KW'(OW'(in_ch.row)) * KW'(IN_MAX) + KW'(IW'(in_ch.col));

    assign upd_w = upd_val(r_w_q, r_pl, r_ph);
    assign upd_b = upd_val(r_b_q, r_pl, r_ph);

    // memory port control
    always_comb begin
        w_we  = (r_state == S_CLR) || (r_state == U_ACC) ||
                (acc_in && fn == FN_LDW && ld_w_ok);
        w_re  = (r_state == F_RD) || (r_state == B_RD) || (r_state == U_RD);
        w_a   = (r_state == S_CLR || r_state == U_RD || r_state == U_ACC) ? r_k :
                (r_state == S_IDLE) ? k_ld : k_ij;
        w_d   = (r_state == S_CLR) ? '0 : (r_state == U_ACC) ? upd_w : in_ch.value;

        wg_we = (r_state == S_CLR) || (r_state == B_ACC) || (r_state == U_ACC);
        wg_re = (r_state == B_RD) || (r_state == U_RD);
        wg_a  = (r_state == S_CLR || r_state == U_RD || r_state == U_ACC) ? r_k : k_ij;
        wg_d  = (r_state == B_ACC) ? sat_add(r_wg_q, r_p1) : '0;

        b_we  = (r_state == S_CLR && clr_out) || (r_state == U_BACC) ||
                (acc_in && fn == FN_LDB && ld_b_ok);
        b_re  = (r_state == F_BRD) || (r_state == U_BRD);
        b_a   = (r_state == S_CLR) ? OW'(r_k) :
                (r_state == S_IDLE) ? OW'(in_ch.row) : r_i;
        b_d   = (r_state == S_CLR) ? '0 : (r_state == U_BACC) ? upd_b : in_ch.value;

        bg_we = (r_state == S_CLR && clr_out) || (r_state == B_BACC) ||
                (r_state == U_BACC);
        bg_re = (r_state == B_BRD) || (r_state == U_BRD);
        bg_a  = (r_state == S_CLR) ? OW'(r_k) : r_i;
        bg_d  = (r_state == B_BACC) ? sat_add(r_bg_q, to_acc(r_v)) : '0;

        c_we  = (r_state == S_CLR && clr_in) || (acc_in && fn == FN_FWD && col_ok);
        c_re  = (r_state == F_RD) || (r_state == B_RD);
        c_a   = (r_state == S_CLR) ? IW'(r_k) :
                (r_state == S_IDLE) ? IW'(in_ch.col) : r_j;
        c_d   = (r_state == S_CLR) ? '0 : in_ch.value;

        ga_we = (r_state == S_CLR && clr_in) || (r_state == B_ACC) ||
                (r_state == G_EMIT && slot_free);
        ga_re = (r_state == B_RD) || (r_state == G_RD);
        ga_a  = (r_state == S_CLR) ? IW'(r_k) : r_j;
        ga_d  = (r_state == B_ACC) ? sat_add(r_ga_q, r_p2) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem_w[w_a] <= w_d;
        if (w_re) r_w_q <= mem_w[w_a];
    end

    always_ff @(posedge i_clk) begin
        if (wg_we) mem_wg[wg_a] <= wg_d;
        if (wg_re) r_wg_q <= mem_wg[wg_a];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) mem_b[b_a] <= b_d;
        if (b_re) r_b_q <= mem_b[b_a];
    end

    always_ff @(posedge i_clk) begin
        if (bg_we) mem_bg[bg_a] <= bg_d;
        if (bg_re) r_bg_q <= mem_bg[bg_a];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) mem_c[c_a] <= c_d;
        if (c_re) r_c_q <= mem_c[c_a];
    end

    always_ff @(posedge i_clk) begin
        if (ga_we) mem_ga[ga_a] <= ga_d;
        if (ga_re) r_ga_q <= mem_ga[ga_a];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= CNT_W'(64);
            r_out_count <= CNT_W'(64);
            r_lrate     <= LR_W'(655);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_COUNT:  r_in_count  <= i_cfg_data[CNT_W-1:0];
                CFG_OUT_COUNT: r_out_count <= i_cfg_data[CNT_W-1:0];
                CFG_LRATE:     r_lrate     <= i_cfg_data[LR_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_emit) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_k <= r_k + KW'(1);
                    if (k_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_v    <= in_ch.value;
                        r_last <= in_ch.last;
                        r_j    <= '0;
                        r_k    <= '0;
                        unique case (fn)
                            FN_FWD: begin
                                if (in_ch.last) begin
                                    r_i     <= '0;
                                    r_state <= F_BRD;
                                end
                            end
                            FN_BWD: begin
                                r_i <= OW'(in_ch.row);
                                if (row_ok) r_state <= B_RD;
                                else if (in_ch.last) r_state <= G_RD;
                            end
                            FN_UPD: r_state <= U_RD;
                            default: ;
                        endcase
                    end
                end
                // forward: one output neuron per row walk
                F_BRD:   r_state <= F_BINIT;
                F_BINIT: begin
                    r_acc   <= to_acc(r_b_q);
                    r_j     <= '0;
                    r_state <= F_RD;
                end
                F_RD:  r_state <= F_MUL;
                F_MUL: begin
                    r_p1    <= r_w_q * r_c_q;
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    r_acc <= sat_add(r_acc, r_p1);
                    if (j_last) begin
                        r_state <= F_EMIT;
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= F_RD;
                    end
                end
                F_EMIT: begin
                    if (slot_free) begin
                        r_kind      <= KD_FWD;
                        r_idx       <= IDX_W'(r_i);
                        r_res       <= round_q(r_acc);
                        r_fin       <= i_last;
                        if (i_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + OW'(1);
                            r_state <= F_BRD;
                        end
                    end
                end
                // backward: weight gradient row, bias gradient and grad-input accumulators
                B_RD:  r_state <= B_MUL;
                B_MUL: begin
                    r_p1    <= r_v * r_c_q;
                    r_p2    <= r_w_q * r_v;
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    if (j_last) begin
                        r_state <= B_BRD;
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= B_RD;
                    end
                end
                B_BRD:  r_state <= B_BACC;
                B_BACC: begin
                    r_j     <= '0;
                    r_state <= r_last ? G_RD : S_IDLE;
                end
                // emit and clear the grad-input accumulators
                G_RD:   r_state <= G_EMIT;
                G_EMIT: begin
                    if (slot_free) begin
                        r_kind      <= KD_GRAD;
                        r_idx       <= IDX_W'(r_j);
                        r_res       <= round_q(r_ga_q);
                        r_fin       <= j_last;
                        if (j_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= G_RD;
                        end
                    end
                end
                // update: every weight, then every bias
                U_RD:  r_state <= U_MUL;
                U_MUL: begin
                    r_pl    <= r_lrate * r_wg_q[15:0];
                    r_ph    <= $signed({1'b0, r_lrate}) * $signed(r_wg_q[31:16]);
                    r_state <= U_ACC;
                end
                U_ACC: begin
                    if (k_last) begin
                        r_i     <= '0;
                        r_state <= U_BRD;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= U_RD;
                    end
                end
                U_BRD:  r_state <= U_BMUL;
                U_BMUL: begin
                    r_pl    <= r_lrate * r_bg_q[15:0];
                    r_ph    <= $signed({1'b0, r_lrate}) * $signed(r_bg_q[31:16]);
                    r_state <= U_BACC;
                end
                U_BACC: begin
                    if (iu_last) begin
                        r_state <= U_DONE;
                    end else begin
                        r_i     <= r_i + OW'(1);
                        r_state <= U_BRD;
                    end
                end
                U_DONE: begin
                    if (slot_free) begin
                        r_kind      <= KD_DONE;
                        r_idx       <= '0;
                        r_res       <= '0;
                        r_fin       <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid     = r_out_valid;
    assign out_ch.kind      = r_kind;
    assign out_ch.index     = r_idx;
    assign out_ch.result    = r_res;
    assign out_ch.final_res = r_fin;

    // loads finish in the accept cycle
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && (fn == FN_LDW || fn == FN_LDB) |=> in_ch.ready)
        else $error("load did not return to idle");

    // an update starts its sweep at the first weight
    a_upd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && fn == FN_UPD |=> r_state == U_RD && r_k == '0)
        else $error("update sweep not started at entry zero");

    // forward outputs stay within the active neuron count
    a_fwd_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.kind == KD_FWD |-> LW'(out_ch.index) < no)
        else $error("forward output index beyond out_count");

    // update done is always the end of its run
    a_done_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.kind == KD_DONE |-> out_ch.final_res)
        else $error("update done without final mark");

endmodule

// ===== sim/tb_dense_layer_train_engine.sv =====
// testbench of the dense layer training engine: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb_dense_layer_train_engine;
    import dlte_pkg::*;

    localparam int N_IN  = 64;
    localparam int N_OUT = 64;
    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_RSV5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSV6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSV7 = 3'd7;
    localparam longint ACC_HI = 64'sd2147483647;
    localparam longint ACC_LO = -64'sd2147483648;
    localparam longint DAT_HI = 64'sd32767;
    localparam longint DAT_LO = -64'sd32768;
    // cycles a non-result item may still keep the sequencer busy
    localparam int SETTLE = 3 * N_IN + 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
        bit                has_exp;
        logic [DATA_W-1:0] exp_res;
    } t_layer_op;

    typedef struct {
        t_kind             kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] result;
        logic              fin;
    } t_layer_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    dlte_in_if  in_ch ();
    dlte_out_if out_ch ();

    dense_layer_train_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // shadow copy of the layer state
    longint weights   [N_OUT*N_IN];
    longint biases    [N_OUT];
    longint w_grads   [N_OUT*N_IN];
    longint b_grads   [N_OUT];
    longint act_cache [N_IN];
    longint gin_acc   [N_IN];
    logic [CNT_W-1:0] in_cnt_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [LR_W-1:0]  lrate_reg;

    t_layer_res pending_results [$];
    int  mismatches;
    bit  hold_req;
    bit  send_burst;
    bit  recv_burst;
    int  update_budget;

    // directed table, layer shrunk to 2 inputs x 2 outputs
    t_layer_op directed_ops [21] = '{
        '{FN_FWD,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0, 16'h0},
        '{FN_FWD,  6'd0,  6'd1,  16'h8000, 1'b1, 1, 16'h0000},   // all-zero layer
        '{FN_LDW,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0, 16'h0},
        '{FN_LDW,  6'd0,  6'd1,  16'h8000, 1'b1, 0, 16'h0},
        '{FN_LDB,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0, 16'h0},
        '{FN_LDW,  6'd1,  6'd0,  16'h1000, 1'b0, 0, 16'h0},
        '{FN_LDB,  6'd1,  6'd63, 16'h8000, 1'b0, 0, 16'h0},
        '{FN_LDW,  6'd63, 6'd63, 16'h7FFF, 1'b0, 0, 16'h0},
        '{FN_LDB,  6'd63, 6'd0,  16'h8000, 1'b1, 0, 16'h0},
        '{FN_FWD,  6'd0,  6'd0,  16'h1000, 1'b1, 1, 16'h7FFF},   // neuron 0 saturates high
        '{FN_FWD,  6'd63, 6'd63, 16'h1234, 1'b1, 0, 16'h0},      // col past in_count
        '{FN_BWD,  6'd0,  6'd0,  16'h1000, 1'b0, 0, 16'h0},
        '{FN_BWD,  6'd1,  6'd0,  16'h8000, 1'b0, 0, 16'h0},
        '{FN_BWD,  6'd63, 6'd63, 16'h7FFF, 1'b1, 0, 16'h0},      // row past out_count
        '{FN_RSV5, 6'd3,  6'd3,  16'h5555, 1'b1, 0, 16'h0},
        '{FN_RSV6, 6'd0,  6'd0,  16'hAAAA, 1'b0, 0, 16'h0},
        '{FN_RSV7, 6'd63, 6'd63, 16'hFFFF, 1'b1, 0, 16'h0},
        '{FN_UPD,  6'd0,  6'd0,  16'h0000, 1'b0, 1, 16'h0000},
        '{FN_FWD,  6'd0,  6'd1,  16'hF000, 1'b1, 0, 16'h0},
        '{FN_BWD,  6'd1,  6'd0,  16'h0100, 1'b1, 0, 16'h0},
        '{FN_UPD,  6'd63, 6'd63, 16'hFFFF, 1'b1, 1, 16'h0000}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint acc_add(longint a, longint b);
        return clamp_to(a + clamp_to(b, ACC_LO, ACC_HI), ACC_LO, ACC_HI);
    endfunction

    // q8.24 to q4.12, round half up, saturate
    function automatic longint to_q412(longint acc);
        return clamp_to((acc >>> FRAC) + ((acc >> (FRAC - 1)) & 1), DAT_LO, DAT_HI);
    endfunction

    // w - round(lr * grad), grad split in 16-bit halves
    function automatic longint sgd_step(longint w, longint g);
        longint lr, hi, lo, lowp, stp;
        lr   = longint'(lrate_reg);
        hi   = g >>> 16;
        lo   = g & 64'hFFFF;
        lowp = (lr * lo + (64'sd1 <<< 27)) >>> 16;
        stp  = (lr * hi + lowp) >>> FRAC;
        return clamp_to(w - stp, DAT_LO, DAT_HI);
    endfunction

    function automatic int eff_count(logic [CNT_W-1:0] c, int mx);
        return c == 0 ? 1 : (int'(c) > mx ? mx : int'(c));
    endfunction

    function automatic void push_result(t_kind k, int idx, longint r, bit fin);
        t_layer_res e;
        e.kind   = k;
        e.index  = IDX_W'(idx);
        e.result = DATA_W'(r);
        e.fin    = fin;
        pending_results.push_back(e);
    endfunction

    // advance the shadow layer by one accepted transaction
    function automatic void predict_layer(t_layer_op op);
        int ni, no, k;
        longint v, acc;
        ni = eff_count(in_cnt_reg, N_IN);
        no = eff_count(out_cnt_reg, N_OUT);
        v  = longint'($signed(op.value));
        case (op.func)
            FN_FWD: begin
                if (op.col < ni) act_cache[op.col] = v;
                if (op.last) begin
                    for (int i = 0; i < no; i++) begin
                        acc = acc_add(0, biases[i] * 4096);
                        for (int j = 0; j < ni; j++)
                            acc = acc_add(acc, weights[i*N_IN+j] * act_cache[j]);
                        push_result(KD_FWD, i, to_q412(acc), i == no - 1);
                    end
                end
            end
            FN_BWD: begin
                if (op.row < no) begin
                    for (int j = 0; j < ni; j++) begin
                        k = op.row * N_IN + j;
                        w_grads[k] = acc_add(w_grads[k], v * act_cache[j]);
                        gin_acc[j] = acc_add(gin_acc[j], weights[k] * v);
                    end
                    b_grads[op.row] = acc_add(b_grads[op.row], v * 4096);
                end
                if (op.last) begin
                    for (int j = 0; j < ni; j++) begin
                        push_result(KD_GRAD, j, to_q412(gin_acc[j]), j == ni - 1);
                        gin_acc[j] = 0;
                    end
                end
            end
            FN_UPD: begin
                // every stored weight, not just the ones in use
                for (int k2 = 0; k2 < N_OUT*N_IN; k2++) begin
                    weights[k2] = sgd_step(weights[k2], w_grads[k2]);
                    w_grads[k2] = 0;
                end
                for (int i = 0; i < N_OUT; i++) begin
                    biases[i]  = sgd_step(biases[i], b_grads[i]);
                    b_grads[i] = 0;
                end
                push_result(KD_DONE, 0, 0, 1'b1);
            end
            FN_LDW: weights[op.row*N_IN+op.col] = v;
            FN_LDB: biases[op.row] = v;
            default: ;
        endcase
    endfunction

    // offer one transaction, wait for acceptance, then predict
    task automatic send_op(t_layer_op op);
        int gap, n0;
        if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= op.func;
        in_ch.row   <= op.row;
        in_ch.col   <= op.col;
        in_ch.value <= op.value;
        in_ch.last  <= op.last;
        do @(posedge i_clk); while (!in_ch.ready);
        n0 = pending_results.size();
        predict_layer(op);
        // typed-in value replaces the predicted one on the first result
        if (op.has_exp) pending_results[n0].result = op.exp_res;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register writes stay high across back-to-back calls; caller drops i_cfg_we
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_IN_COUNT:  in_cnt_reg  = data[CNT_W-1:0];
            CFG_OUT_COUNT: out_cnt_reg = data[CNT_W-1:0];
            CFG_LRATE:     lrate_reg   = data[LR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_layer(int ic, int oc, int lr);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_IN_COUNT, CFG_W'(ic));
        write_reg(CFG_OUT_COUNT, CFG_W'(oc));
        write_reg(CFG_LRATE, CFG_W'(lr));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return DATA_W'($signed(16'($urandom)) >>> $urandom_range(0, 4));
        endcase
    endfunction

    // one random sequence; returns the number of transactions sent, not counting reserved codes
    task automatic random_sequence(output int sent);
        t_layer_op op;
        int ni, no, len, pick;
        ni   = eff_count(in_cnt_reg, N_IN);
        no   = eff_count(out_cnt_reg, N_OUT);
        pick = $urandom_range(0, 99);
        sent = 0;
        op.has_exp = 0;
        op.exp_res = '0;
        if (pick < 40) begin
            // forward vector, small layers in order, large ones a random subset
            len = ni <= 8 ? ni : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                op.func  = FN_FWD;
                op.row   = IDX_W'($urandom);
                op.col   = ni <= 8 ? IDX_W'(j) : IDX_W'($urandom_range(0, ni - 1));
                if ($urandom_range(0, 9) == 0) op.col = IDX_W'($urandom);
                op.value = rand_value();
                op.last  = j == len - 1;
                send_op(op);
                sent++;
            end
        end else if (pick < 75) begin
            len = $urandom_range(1, no < 6 ? no : 6);
            for (int j = 0; j < len; j++) begin
                op.func  = FN_BWD;
                op.row   = $urandom_range(0, 9) == 0 ? IDX_W'($urandom)
                                                      : IDX_W'($urandom_range(0, no - 1));
                op.col   = IDX_W'($urandom);
                op.value = rand_value();
                op.last  = j == len - 1;
                send_op(op);
                sent++;
            end
        end else if (pick < 90) begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
                op.func  = $urandom_range(0, 1) ? FN_LDW : FN_LDB;
                op.row   = $urandom_range(0, 3) == 0 ? IDX_W'($urandom)
                                                      : IDX_W'($urandom_range(0, no - 1));
                op.col   = $urandom_range(0, 3) == 0 ? IDX_W'($urandom)
                                                      : IDX_W'($urandom_range(0, ni - 1));
                op.value = rand_value();
                op.last  = 1'($urandom);
                send_op(op);
                sent++;
            end
        end else if (pick < 95 && update_budget > 0) begin
            update_budget--;
            op.func  = FN_UPD;
            op.row   = IDX_W'($urandom);
            op.col   = IDX_W'($urandom);
            op.value = DATA_W'($urandom);
            op.last  = 1'($urandom);
            send_op(op);
            sent++;
        end else begin
            // noise: ignored codes, or an out-of-range forward element
            op.row   = IDX_W'($urandom);
            op.col   = IDX_W'($urandom);
            op.value = DATA_W'($urandom);
            op.last  = 1'($urandom);
            case ($urandom_range(0, 3))
                0: op.func = FN_RSV5;
                1: op.func = FN_RSV6;
                2: op.func = FN_RSV7;
                default: begin
                    op.func = FN_FWD;
                    op.col  = IDX_W'($urandom_range(ni, 63));
                    op.last = 1'b0;
                    sent++;
                end
            endcase
            send_op(op);
        end
    endtask

    task automatic random_phase(int quota);
        int total, n;
        total = 0;
        while (total < quota) begin
            random_sequence(n);
            total += n;
        end
    endtask

    // result side: random stalls, bursts, and one long hold-off on request
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        recv_burst   = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
                stall = recv_burst ? 0 : $urandom_range(0, 6);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // compare every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_layer_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: kind %0d index %0d result %h final %b",
                             out_ch.kind, out_ch.index, out_ch.result, out_ch.final_res);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (out_ch.kind !== e.kind || out_ch.index !== e.index ||
                    out_ch.result !== e.result || out_ch.final_res !== e.fin) begin
                    if (mismatches < 10)
                        $display({"mismatch: exp kind %0d index %0d result %h final %b,",
                                  " got %0d %0d %h %b"},
                                 e.kind, e.index, e.result, e.fin, out_ch.kind,
                                 out_ch.index, out_ch.result, out_ch.final_res);
                    mismatches++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int wait_cycles;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_IN_COUNT;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.func   = FN_FWD;
        in_ch.row    = '0;
        in_ch.col    = '0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        mismatches   = 0;
        hold_req     = 1'b0;
        send_burst   = 1'b0;
        update_budget = 5;
        foreach (weights[k]) begin
            weights[k] = 0;
            w_grads[k] = 0;
        end
        foreach (biases[i]) begin
            biases[i]  = 0;
            b_grads[i] = 0;
        end
        foreach (act_cache[j]) begin
            act_cache[j] = 0;
            gin_acc[j]   = 0;
        end
        in_cnt_reg  = CNT_W'(64);
        out_cnt_reg = CNT_W'(64);
        lrate_reg   = LR_W'(655);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on a 2x2 layer; the clearing pass ends on its own
        set_layer(2, 2, 655);
        foreach (directed_ops[n]) send_op(directed_ops[n]);

        set_layer(3, 4, 655);
        random_phase(32);
        // long result-side hold-off during the next random phase
        hold_req = 1'b1;
        random_phase(12);
        // sender waits for every outstanding result before going on
        drain_results();
        random_phase(10);
        // counts 0 and 127 act as 1 and 64
        set_layer(0, 127, 65535);
        random_phase(20);
        set_layer(1, 1, 0);
        random_phase(24);
        set_layer(127, 0, 4096);
        random_phase(12);
        set_layer(5, 3, 30000);
        random_phase(32);
        set_layer(64, 64, 655);
        random_phase(12);
        set_layer(8, 6, 1234);
        random_phase(36);

        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
